// ===== hdl/exlex_pkg.sv =====
// Shared types, constants and helper functions of the expression lexer.
// Depends on nothing; all other files but exlex_ifs refer to it by scoped names.
`timescale 1ns / 1ps

package exlex_pkg;

   // Text size limit and the saturation points that follow from it.
   localparam int MAX_TEXT_BYTES = 65536;
   localparam int POS_LIMIT_INT  = (MAX_TEXT_BYTES - 1 > 65535) ? 65535 : MAX_TEXT_BYTES - 1;
   localparam int LEN_LIMIT_INT  = (MAX_TEXT_BYTES > 65535) ? 65535 : MAX_TEXT_BYTES;
   localparam logic [15:0] POS_LIMIT = 16'(POS_LIMIT_INT);
   localparam logic [15:0] LEN_LIMIT = 16'(LEN_LIMIT_INT);

   // Bundle queue between the front and the back end; the depth must be a power of two.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      KIND_EOI     = 4'd0,
      KIND_UNKNOWN = 4'd1,
      KIND_IDENT   = 4'd2,
      KIND_NUMBER  = 4'd3,
      KIND_COMMA   = 4'd4,
      KIND_COLON   = 4'd5,
      KIND_PLUS    = 4'd6,
      KIND_MINUS   = 4'd7,
      KIND_STAR    = 4'd8,
      KIND_SLASH   = 4'd9,
      KIND_LPAREN  = 4'd10,
      KIND_RPAREN  = 4'd11,
      KIND_WITH    = 4'd12
   } token_kind_type;

   typedef struct packed {
      token_kind_type kind;
      logic [15:0]    start;
      logic [15:0]    length;
   } token_type;

   // All tokens caused by one input byte, in order; count is 1 to 3.
   typedef struct packed {
      logic [1:0]          count;
      token_type [2:0]     tok;
   } bundle_type;

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_VT     = 8'h0B;
   localparam logic [7:0] CHAR_FF     = 8'h0C;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_COLON  = 8'h3A;
   localparam logic [7:0] CHAR_UP_A   = 8'h41;
   localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
   localparam logic [7:0] CHAR_LOW_A  = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;

   // Keyword match progress: 0 to 4 letters of "with" matched, or dead.
   localparam logic [2:0] KW_NONE = 3'd0;
   localparam logic [2:0] KW_FULL = 3'd4;
   localparam logic [2:0] KW_DEAD = 3'd7;

   function automatic logic [7:0] kw_char(logic [1:0] idx);
      logic [7:0] c;
      unique case (idx)
         2'd0: c = 8'h77;
         2'd1: c = 8'h69;
         2'd2: c = 8'h74;
         2'd3: c = 8'h68;
      endcase
      return c;
   endfunction

   function automatic logic [2:0] kw_advance(logic [2:0] kw, logic [7:0] c);
      logic [2:0] r;
      if (kw < KW_FULL && c == kw_char(kw[1:0])) begin
         r = kw + 3'd1;
      end else begin
         r = KW_DEAD;
      end
      return r;
   endfunction

   function automatic token_kind_type single_kind(logic [7:0] c);
      token_kind_type k;
      unique case (c)
         CHAR_COMMA:  k = KIND_COMMA;
         CHAR_COLON:  k = KIND_COLON;
         CHAR_PLUS:   k = KIND_PLUS;
         CHAR_MINUS:  k = KIND_MINUS;
         CHAR_STAR:   k = KIND_STAR;
         CHAR_SLASH:  k = KIND_SLASH;
         CHAR_LPAREN: k = KIND_LPAREN;
         CHAR_RPAREN: k = KIND_RPAREN;
         default:     k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

   function automatic logic is_letter(logic [7:0] c);
      return (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) || (c >= CHAR_UP_A && c <= CHAR_UP_Z);
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_FF || c == CHAR_VT
          || c == CHAR_CR || c == CHAR_LF;
   endfunction

endpackage

// ===== hdl/exlex_ifs.sv =====
// Valid/ready channel interfaces of the expression lexer: text bytes in, tokens out.
// Depends on nothing.
`timescale 1ns / 1ps

interface exlex_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface exlex_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [15:0] token_start;
   logic [15:0] token_length;
   logic        last_of_run;

   modport source (output valid, output token_kind, output token_start,
                   output token_length, output last_of_run, input ready);
   modport sink (input valid, input token_kind, input token_start,
                 input token_length, input last_of_run, output ready);
endinterface

// ===== hdl/exlex_front.sv =====
// Front end of the lexer: takes text bytes, keeps the scanning state and builds
// the bundle of tokens each byte causes. Depends on exlex_pkg and exlex_req_if.
`timescale 1ns / 1ps

module exlex_front (
   input  logic                  clock,
   input  logic                  reset,
   exlex_req_if.sink             req_if,
   output logic                  push_valid,
   input  logic                  push_ready,
   output exlex_pkg::bundle_type push_bundle
);

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_IDENT  = 2'd1,
      MODE_NUMBER = 2'd2
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [15:0] start_ff, start_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] pos_ff, pos_in;
   logic [2:0]  kw_ff, kw_in;

   logic                  accept;
   logic [7:0]            c;
   logic                  letter, digit, extended;
   logic [1:0]            n;
   exlex_pkg::token_type [2:0] toks;

   assign c      = req_if.text_byte;
   assign letter = exlex_pkg::is_letter(c);
   assign digit  = exlex_pkg::is_digit(c);

   assign req_if.ready = push_ready;
   assign accept       = req_if.valid && push_ready;

   always_comb begin
      mode_in   = mode_ff;
      start_in  = start_ff;
      length_in = length_ff;
      pos_in    = pos_ff;
      kw_in     = kw_ff;
      n         = 2'd0;
      toks      = '0;
      extended  = 1'b0;

      if (c == exlex_pkg::CHAR_NUL) begin
         if (mode_ff != MODE_IDLE) begin
            toks[n] = '{kind: (mode_ff == MODE_NUMBER) ? exlex_pkg::KIND_NUMBER :
                              (kw_ff == exlex_pkg::KW_FULL) ? exlex_pkg::KIND_WITH :
                              exlex_pkg::KIND_IDENT,
                        start: start_ff, length: length_ff};
            n = n + 2'd1;
         end
         toks[n] = '{kind: exlex_pkg::KIND_EOI, start: pos_ff, length: 16'd0};
         n = n + 2'd1;
         mode_in   = MODE_IDLE;
         start_in  = '0;
         length_in = '0;
         kw_in     = exlex_pkg::KW_NONE;
         pos_in    = '0;
      end else begin
         extended = (mode_ff == MODE_IDENT && letter) || (mode_ff == MODE_NUMBER && digit);
         if (extended) begin
            if (mode_ff == MODE_IDENT) begin
               kw_in = exlex_pkg::kw_advance(kw_ff, c);
            end
            if (length_ff < exlex_pkg::LEN_LIMIT) begin
               length_in = length_ff + 16'd1;
            end
         end else begin
            if (mode_ff != MODE_IDLE) begin
               toks[n] = '{kind: (mode_ff == MODE_NUMBER) ? exlex_pkg::KIND_NUMBER :
                                 (kw_ff == exlex_pkg::KW_FULL) ? exlex_pkg::KIND_WITH :
                                 exlex_pkg::KIND_IDENT,
                           start: start_ff, length: length_ff};
               n = n + 2'd1;
            end
            mode_in   = MODE_IDLE;
            start_in  = '0;
            length_in = '0;
            kw_in     = exlex_pkg::KW_NONE;
            if (letter) begin
               mode_in   = MODE_IDENT;
               start_in  = pos_ff;
               length_in = 16'd1;
               kw_in     = exlex_pkg::kw_advance(exlex_pkg::KW_NONE, c);
            end else if (digit) begin
               mode_in   = MODE_NUMBER;
               start_in  = pos_ff;
               length_in = 16'd1;
            end else if (!exlex_pkg::is_blank(c)) begin
               toks[n] = '{kind: exlex_pkg::single_kind(c), start: pos_ff, length: 16'd1};
               n = n + 2'd1;
            end
         end

         if (pos_ff < exlex_pkg::POS_LIMIT) begin
            pos_in = pos_ff + 16'd1;
         end

         // The end flag closes whatever run this byte left open, then marks end of input
         // just past the byte.
         if (req_if.end_of_text) begin
            if (mode_in != MODE_IDLE) begin
               toks[n] = '{kind: (mode_in == MODE_NUMBER) ? exlex_pkg::KIND_NUMBER :
                                 (kw_in == exlex_pkg::KW_FULL) ? exlex_pkg::KIND_WITH :
                                 exlex_pkg::KIND_IDENT,
                           start: start_in, length: length_in};
               n = n + 2'd1;
            end
            toks[n] = '{kind: exlex_pkg::KIND_EOI, start: pos_in, length: 16'd0};
            n = n + 2'd1;
            mode_in   = MODE_IDLE;
            start_in  = '0;
            length_in = '0;
            kw_in     = exlex_pkg::KW_NONE;
            pos_in    = '0;
         end
      end
   end

   assign push_valid        = accept && (n != 2'd0);
   assign push_bundle.count = n;
   assign push_bundle.tok   = toks;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         start_ff  <= '0;
         length_ff <= '0;
         pos_ff    <= '0;
         kw_ff     <= exlex_pkg::KW_NONE;
      end else if (accept) begin
         mode_ff   <= mode_in;
         start_ff  <= start_in;
         length_ff <= length_in;
         pos_ff    <= pos_in;
         kw_ff     <= kw_in;
      end
   end

endmodule

// ===== hdl/exlex_queue.sv =====
// Short queue of token bundles between the front and back end of the lexer.
// Depends on exlex_pkg.
`timescale 1ns / 1ps

module exlex_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  exlex_pkg::bundle_type push_bundle,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output exlex_pkg::bundle_type pop_bundle
);

   exlex_pkg::bundle_type                entries_ff [exlex_pkg::QUEUE_DEPTH];
   logic [exlex_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [exlex_pkg::QUEUE_CNT_W-1:0]    count_ff;
   logic                                 do_push, do_pop;

   assign push_ready = count_ff != exlex_pkg::QUEUE_CNT_W'(exlex_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_bundle = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   // Pointers wrap on their own since the depth is a power of two.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hdl/exlex_back.sv =====
// Back end of the lexer: takes bundles from the queue and sends their tokens
// one per transfer through an output register. Depends on exlex_pkg and exlex_rsp_if.
`timescale 1ns / 1ps

module exlex_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  exlex_pkg::bundle_type pop_bundle,
   exlex_rsp_if.source           rsp_if
);

   exlex_pkg::bundle_type cur_ff;
   logic                  busy_ff;
   logic [1:0]            idx_ff;
   logic                  out_valid_ff;
   exlex_pkg::token_type  out_tok_ff;
   logic                  out_last_ff;
   logic                  load, last;

   assign load      = busy_ff && (!out_valid_ff || rsp_if.ready);
   assign last      = idx_ff == (cur_ff.count - 2'd1);
   assign pop_ready = !busy_ff || (load && last);

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.token_kind   = out_tok_ff.kind;
   assign rsp_if.token_start  = out_tok_ff.start;
   assign rsp_if.token_length = out_tok_ff.length;
   assign rsp_if.last_of_run  = out_last_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         out_tok_ff  <= cur_ff.tok[idx_ff];
         out_last_ff <= last;
      end
      if (pop_valid && pop_ready) begin
         cur_ff <= pop_bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            out_valid_ff <= 1'b1;
            idx_ff       <= last ? 2'd0 : idx_ff + 2'd1;
            if (last) begin
               busy_ff <= 1'b0;
            end
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
         // A new bundle takes over in the same cycle the old one sends its last token.
         if (pop_valid && pop_ready) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end
      end
   end

endmodule

// ===== hdl/expression_lexer_core.sv =====
// Top level of the streaming expression lexer: front end, bundle queue, back end.
// Depends on exlex_pkg, exlex_ifs, exlex_front, exlex_queue and exlex_back.
//
// Usage: text bytes arrive on req_if (text_byte, end_of_text), one per transfer.
// Tokens leave on rsp_if (token_kind, token_start, token_length, last_of_run),
// one per transfer; last_of_run marks the final token caused by one byte.
// A byte may cause no token (blanks, growing runs) or up to three tokens.
// The front end takes one byte per cycle while the two-entry bundle queue has
// room. The back end sends one token per cycle from its output register while
// the receiver is ready, so a byte that causes three tokens holds the output
// for all three in turn. A byte reaches its first token through the queue
// write, the back-end bundle register and the output register.
// When the receiver stalls, the output holds and the queue fills; req_if.ready
// drops only once the queue is full.
// Reset (synchronous, active high) returns the scanner to idle at offset zero
// and empties the queue and the output register.
`timescale 1ns / 1ps

module expression_lexer_core (
   input  logic       clock,
   input  logic       reset,
   exlex_req_if.sink  req_if,
   exlex_rsp_if.source rsp_if
);

   logic                  push_valid, push_ready;
   logic                  pop_valid, pop_ready;
   exlex_pkg::bundle_type push_bundle, pop_bundle;

   exlex_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_bundle (push_bundle)
   );

   exlex_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_bundle (push_bundle),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_bundle  (pop_bundle)
   );

   exlex_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_bundle (pop_bundle),
      .rsp_if     (rsp_if)
   );

endmodule
